@@ hdl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

@@ hdl/utf8f_pkg.sv @@
`timescale 1ns / 1ps

package utf8f_pkg;

  localparam int MAX_RES = 4;            // most results one byte can release
  localparam int RES_CW  = 3;            // width of a result count 0..MAX_RES
  localparam int HELD_N  = 3;
  localparam int QDEPTH  = 8;
  localparam int QAW     = $clog2(QDEPTH);
  localparam int QCW     = $clog2(QDEPTH + 1);

  localparam logic [7:0] ASCII_END  = 8'h80;
  localparam logic [7:0] LEAD2_MIN  = 8'hC2;
  localparam logic [7:0] LEAD3_MIN  = 8'hE0;
  localparam logic [7:0] LEAD4_MIN  = 8'hF0;
  localparam logic [7:0] LEAD_END   = 8'hF5;
  localparam logic [7:0] LEAD_E0    = 8'hE0;
  localparam logic [7:0] LEAD_ED    = 8'hED;
  localparam logic [7:0] LEAD_F0    = 8'hF0;
  localparam logic [7:0] LEAD_F4    = 8'hF4;
  localparam logic [7:0] CONT_A0    = 8'hA0;
  localparam logic [7:0] CONT_90    = 8'h90;
  localparam logic [1:0] CONT_TAG   = 2'b10;

  localparam logic [2:0] SEQ_LEN2 = 3'd2;
  localparam logic [2:0] SEQ_LEN3 = 3'd3;
  localparam logic [2:0] SEQ_LEN4 = 3'd4;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       keep;
    logic       run_end;
    logic       payload_end;
  } result_t;

  typedef struct packed {
    logic [HELD_N-1:0][7:0] held;
    logic [1:0]             count;
    logic [2:0]             exp_len;
  } seq_state_t;

  typedef struct packed {
    logic [QCW-1:0] level;
    logic           room;
  } queue_status_t;

endpackage

@@ hdl/utf8f_if.sv @@
`timescale 1ns / 1ps

interface utf8f_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       payload_last;

  modport source (output valid, data_byte, payload_last, input ready);
  modport sink (input valid, data_byte, payload_last, output ready);
endinterface

interface utf8f_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       keep;
  logic       run_end;
  logic       payload_end;

  modport source (output valid, out_byte, keep, run_end, payload_end, input ready);
  modport sink (input valid, out_byte, keep, run_end, payload_end, output ready);
endinterface

@@ hdl/utf8f_decide.sv @@
`timescale 1ns / 1ps

module utf8f_decide
  import utf8f_pkg::*;
(
  input  seq_state_t                cur,
  input  logic [7:0]                data_byte,
  input  logic                      payload_last,
  output seq_state_t                nxt,
  output result_t [MAX_RES-1:0]     res,
  output logic [RES_CW-1:0]         res_n
);

  logic       follows;
  logic       do_fresh;
  logic [7:0] lead;

  always_comb begin
    lead    = cur.held[0];
    follows = (data_byte[7:6] == CONT_TAG);
    if (cur.count == 2'd1) begin
      if (lead == LEAD_E0 && data_byte < CONT_A0) follows = 1'b0;
      if (lead == LEAD_ED && data_byte >= CONT_A0) follows = 1'b0;
      if (lead == LEAD_F0 && data_byte < CONT_90) follows = 1'b0;
      if (lead == LEAD_F4 && data_byte >= CONT_90) follows = 1'b0;
    end
  end

  always_comb begin
    nxt      = cur;
    res      = '0;
    res_n    = '0;
    do_fresh = 1'b0;

    if (cur.count == 2'd0) begin
      do_fresh = 1'b1;
    end else if (follows) begin
      if ({1'b0, cur.count} + 3'd1 >= cur.exp_len) begin
        // sequence complete: release it whole
        for (int i = 0; i < HELD_N; i++) begin
          if (2'(i) < cur.count) begin
            res[res_n[1:0]] = '{cur.held[i], 1'b1, 1'b0, 1'b0};
            res_n = res_n + 3'd1;
          end
        end
        res[res_n[1:0]] = '{data_byte, 1'b1, 1'b0, 1'b0};
        res_n = res_n + 3'd1;
        nxt = '0;
      end else begin
        nxt.held[cur.count] = data_byte;
        nxt.count           = cur.count + 2'd1;
      end
    end else begin
      // broken sequence: drop what is held, retry the byte as a lead
      for (int i = 0; i < HELD_N; i++) begin
        if (2'(i) < cur.count) begin
          res[res_n[1:0]] = '{cur.held[i], 1'b0, 1'b0, 1'b0};
          res_n = res_n + 3'd1;
        end
      end
      nxt      = '0;
      do_fresh = 1'b1;
    end

    if (do_fresh) begin
      if (data_byte < ASCII_END) begin
        res[res_n[1:0]] = '{data_byte, 1'b1, 1'b0, 1'b0};
        res_n = res_n + 3'd1;
      end else if (data_byte < LEAD2_MIN || data_byte >= LEAD_END) begin
        res[res_n[1:0]] = '{data_byte, 1'b0, 1'b0, 1'b0};
        res_n = res_n + 3'd1;
      end else begin
        nxt.held[0] = data_byte;
        nxt.count   = 2'd1;
        if (data_byte < LEAD3_MIN) begin
          nxt.exp_len = SEQ_LEN2;
        end else if (data_byte < LEAD4_MIN) begin
          nxt.exp_len = SEQ_LEN3;
        end else begin
          nxt.exp_len = SEQ_LEN4;
        end
      end
    end

    if (payload_last) begin
      // end of payload: drop anything left over
      for (int i = 0; i < HELD_N; i++) begin
        if (2'(i) < nxt.count) begin
          res[res_n[1:0]] = '{nxt.held[i], 1'b0, 1'b0, 1'b0};
          res_n = res_n + 3'd1;
        end
      end
      nxt = '0;
    end

    if (res_n != '0) begin
      res[2'(res_n - 3'd1)].run_end     = 1'b1;
      res[2'(res_n - 3'd1)].payload_end = payload_last;
    end
  end

endmodule

@@ hdl/utf8f_queue.sv @@
`timescale 1ns / 1ps

module utf8f_queue
  import utf8f_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  result_t [MAX_RES-1:0]  res,
  input  logic [RES_CW-1:0]      push_n,
  output queue_status_t          status,
  utf8f_out_if.source            dst
);

  result_t        mem [QDEPTH];
  logic [QAW-1:0] head;
  logic [QAW-1:0] tail;
  logic [QCW-1:0] level;
  logic           pop;

  assign pop          = dst.valid && dst.ready;
  assign status.level = level;
  assign status.room  = (level <= QCW'(QDEPTH - MAX_RES));

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (RES_CW'(i) < push_n) begin
        mem[tail + QAW'(i)] <= res[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      level <= '0;
    end else begin
      tail  <= tail + QAW'(push_n);
      if (pop) head <= head + QAW'(1);
      level <= level + QCW'(push_n) - QCW'(pop);
    end
  end

  assign dst.valid       = (level != '0);
  assign dst.out_byte    = mem[head].out_byte;
  assign dst.keep        = mem[head].keep;
  assign dst.run_end     = mem[head].run_end;
  assign dst.payload_end = mem[head].payload_end;

endmodule

@@ hdl/utf8_invalid_byte_filter.sv @@
`timescale 1ns / 1ps

// Channel  Dir  Item                                        Handshake
// raw      in   data_byte[7:0], payload_last                valid/ready
// filt     out  out_byte[7:0], keep, run_end, payload_end   valid/ready
//
// One input byte per cycle while raw.ready is high; each byte is released
// exactly once, one result per cycle while filt is ready, from an 8-entry
// result queue. A byte is decided when taken, on filt next cycle at earliest.
// raw.ready is high while the queue has room for the 4 results one byte can
// release, so a stalled filt side holds off raw after a few bytes.
// Reset (rst, synchronous) empties the queue and clears the held sequence.

module utf8_invalid_byte_filter
  import utf8f_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  utf8f_in_if.sink    raw,
  utf8f_out_if.source filt
);

  seq_state_t            state;
  seq_state_t            state_next;
  result_t [MAX_RES-1:0] res;
  logic [RES_CW-1:0]     res_n;
  logic [RES_CW-1:0]     push_n;
  queue_status_t         qstat;
  logic                  accept;

  assign raw.ready = qstat.room;
  assign accept    = raw.valid && raw.ready;
  assign push_n    = accept ? res_n : '0;

  utf8f_decide u_decide (
    .cur          (state),
    .data_byte    (raw.data_byte),
    .payload_last (raw.payload_last),
    .nxt          (state_next),
    .res          (res),
    .res_n        (res_n)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  utf8f_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .res    (res),
    .push_n (push_n),
    .status (qstat),
    .dst    (filt)
  );

`include "assert_macros.svh"

  `ASSERT_IMP(a_queue_bound, 1'b1, qstat.level <= QCW'(QDEPTH))
  `ASSERT_NXT(a_last_clears, accept && raw.payload_last, state.count == 2'd0)
  `ASSERT_IMP(a_len_covers, state.count != 2'd0, state.exp_len > {1'b0, state.count})
  `ASSERT_IMP(a_idle_len, state.count == 2'd0, state.exp_len == 3'd0)

endmodule
